// ===== hw/rtl/ook_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and sine table builder for the OOK Barker-13 modulator.
// No dependencies; imported by ook_barker_modulator, ook_in_reg and ook_sym_gen.
package ook_pkg;

    localparam int unsigned MSG_BYTES_DEF      = 16;
    localparam int unsigned PHASE_BITS_DEF     = 16;
    localparam int unsigned SINE_ADDR_BITS_DEF = 10;

    localparam int unsigned SYNC_LEN = 13;
    // first transmitted Barker bit in bit 0
    localparam logic [SYNC_LEN-1:0] BARKER_SEQ = 13'b1010110011111;

    localparam logic [7:0] DAC_MID = 8'd128;
    localparam logic [7:0] DAC_TOP = 8'd255;
    localparam logic [7:0] DAC_BOT = 8'd1;

    localparam logic [15:0] SPS_RESET    = 16'd1100;
    localparam logic [14:0] STEP_RESET   = 15'd1192;
    localparam logic [7:0]  REPEAT_RESET = 8'd30;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        REG_SPS    = 2'd0,
        REG_STEP   = 2'd1,
        REG_REPEAT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] data_byte;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [7:0] dac_sample;
        logic       active;
        logic       current_bit;
        logic       frame_end;
        logic       all_done;
    } result_t;

    typedef struct packed {
        logic [15:0] sym_samples;
        logic [14:0] phase_step;
        logic [7:0]  repeat_count;
    } cfg_t;

    // floor(127*sin(pi*q/2^(abits-1))) clipped to 0..127, Q30 Taylor series.
    // Used only to build constant tables at elaboration.
    function automatic logic [6:0] sine_frac(input int unsigned q, input int unsigned abits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        f;
        x    = (64'(q) * PI_Q30) >> (abits - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        f = (64'd127 * 64'(sum)) >> 30;
        if (f > 64'd127) begin
            f = 64'd127;
        end
        return f[6:0];
    endfunction

endpackage

// ===== hw/rtl/ook_barker_modulator.sv =====
`timescale 1ns / 1ps
// Top level of the OOK Barker-13 modulator: register port, input stage, core, output register.
// Depends on ook_pkg, ook_in_reg, ook_sym_gen (and through it ook_ram).
//
//  port group | direction | carries
//  -----------+-----------+------------------------------------------------------
//  s_*        | in        | load byte or sample tick (tuser = func, tlast = end)
//  m_*        | out       | one DAC sample per tick (tlast = frame end)
//  cfg_*      | in        | register writes, index 0..2
//
// One transaction per cycle sustained while no tick waits on a stalled m_, loads and ticks alike;
// a tick's sample passes the input register, one core pass, then the output register to m_.
// Reset clears all control state; the message store holds no reset value.
// A stalled m_ side holds the sample; the next tick waits in the input register
// and holds off s_ until the sample is taken.
module ook_barker_modulator #(
    parameter int unsigned MSG_BYTES      = ook_pkg::MSG_BYTES_DEF,
    parameter int unsigned PHASE_BITS     = ook_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_ADDR_BITS = ook_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] dac_sample
    output logic        m_tlast,
    output logic [2:0]  m_tuser,   // [0] active, [1] current_bit, [2] all_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ook_pkg::*;

    cfg_t    cfg_reg;
    item_t   s_item;
    item_t   item;
    logic    item_go;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sym_samples  <= SPS_RESET;
            cfg_reg.phase_step   <= STEP_RESET;
            cfg_reg.repeat_count <= REPEAT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_SPS:    cfg_reg.sym_samples  <= cfg_data;
                REG_STEP:   cfg_reg.phase_step   <= cfg_data[14:0];
                REG_REPEAT: cfg_reg.repeat_count <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign s_item.func           = func_t'(s_tuser);
    assign s_item.data_byte      = s_tdata;
    assign s_item.end_of_message = s_tlast;

    ook_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_item   (s_item),
        .out_busy (out_valid_reg && !m_tready),
        .item_go  (item_go),
        .item     (item)
    );

    ook_sym_gen #(
        .MSG_BYTES      (MSG_BYTES),
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item_go (item_go),
        .item    (item),
        .result  (result)
    );

    assign out_load = item_go && (item.func == FUNC_TICK);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.dac_sample;
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = {out_reg.all_done, out_reg.current_bit, out_reg.active};

endmodule

// ===== hw/rtl/ook_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read and write-through bypass.
// No dependencies.
module ook_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data <= wr_data;
        end else begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ook_in_reg.sv =====
`timescale 1ns / 1ps
// Input holding register: takes one transaction per cycle unless a held tick
// waits on out_busy, and releases it to the core. Depends on ook_pkg.
module ook_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ook_pkg::item_t s_item,
    input  logic           out_busy,
    output logic           item_go,
    output ook_pkg::item_t item
);
    import ook_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // a load never produces a result, so it never waits on the output side
    assign item_go = valid_reg && ((item_reg.func == FUNC_LOAD) || !out_busy);
    assign s_ready = !valid_reg || item_go;
    assign item    = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_go) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hw/rtl/ook_sym_gen.sv =====
`timescale 1ns / 1ps
// Frame sequencer: message store, symbol and bit counters, carrier phase and sine lookup.
// Depends on ook_pkg and ook_ram.
module ook_sym_gen #(
    parameter int unsigned MSG_BYTES      = ook_pkg::MSG_BYTES_DEF,
    parameter int unsigned PHASE_BITS     = ook_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_ADDR_BITS = ook_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ook_pkg::cfg_t    cfg,
    input  logic             item_go,
    input  ook_pkg::item_t   item,
    output ook_pkg::result_t result
);
    import ook_pkg::*;

    localparam int unsigned ADDR_W  = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int unsigned CNT_W   = $clog2(MSG_BYTES + 1);
    localparam int unsigned IDX_W   = $clog2(MSG_BYTES * 8 + SYNC_LEN);
    localparam int unsigned CMP_W   = IDX_W + 1;
    localparam int unsigned SUM_W   = (PHASE_BITS > 15) ? PHASE_BITS : 15;
    localparam int unsigned HALF    = 1 << (SINE_ADDR_BITS - 1);
    localparam int unsigned QUARTER = 1 << (SINE_ADDR_BITS - 2);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [15:0]           scnt_reg, scnt_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [7:0]            rep_reg, rep_next;
    logic                  tx_reg, tx_next;

    logic                  wr_en;
    logic [7:0]            rd_byte;

    logic [6:0]            qlut [QUARTER];

    logic [CMP_W-1:0]      msg_bits;
    logic [CMP_W-1:0]      nbits;
    logic [CMP_W-1:0]      bark_pos;
    logic                  bit_val;
    logic [16:0]           sps_eff;
    logic                  last_sample;
    logic                  last_bit;
    logic                  fe;
    logic                  done;

    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [SINE_ADDR_BITS-1:0] r_ext;
    logic [SINE_ADDR_BITS-2:0] q;
    logic                      neg;
    logic [6:0]                frac;
    logic [7:0]                sine_val;

    for (genvar k = 0; k < QUARTER; k++) begin : g_qlut
        assign qlut[k] = sine_frac(k, SINE_ADDR_BITS);
    end

    ook_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(count_reg)),
        .wr_data (item.data_byte),
        .rd_addr (ADDR_W'(idx_next >> 3)),
        .rd_data (rd_byte)
    );

    // frame bit for the current index
    always_comb begin
        msg_bits = CMP_W'({count_reg, 3'b000});
        nbits    = msg_bits + CMP_W'(SYNC_LEN);
        bark_pos = CMP_W'(idx_reg) - msg_bits;
        if (CMP_W'(idx_reg) < msg_bits) begin
            bit_val = rd_byte[3'd7 - idx_reg[2:0]];
        end else if (bark_pos < CMP_W'(SYNC_LEN)) begin
            bit_val = BARKER_SEQ[bark_pos[3:0]];
        end else begin
            bit_val = 1'b0;
        end
    end

    // sine lookup on a quarter wave
    always_comb begin
        sine_addr = SINE_ADDR_BITS'({phase_reg, {SINE_ADDR_BITS{1'b0}}} >> PHASE_BITS);
        neg       = sine_addr[SINE_ADDR_BITS-1];
        r_ext     = {1'b0, sine_addr[SINE_ADDR_BITS-2:0]};
        if (r_ext <= SINE_ADDR_BITS'(QUARTER)) begin
            q = r_ext[SINE_ADDR_BITS-2:0];
        end else begin
            q = (SINE_ADDR_BITS-1)'(SINE_ADDR_BITS'(HALF) - r_ext);
        end
        frac = qlut[q[SINE_ADDR_BITS-3:0]];
        if (q == '0) begin
            sine_val = DAC_MID;
        end else if (q == (SINE_ADDR_BITS-1)'(QUARTER)) begin
            sine_val = neg ? DAC_BOT : DAC_TOP;
        end else if (neg) begin
            sine_val = 8'd127 - {1'b0, frac};
        end else begin
            sine_val = DAC_MID + {1'b0, frac};
        end
    end

    always_comb begin
        sps_eff     = (cfg.sym_samples == '0) ? 17'd1 : {1'b0, cfg.sym_samples};
        last_sample = ({1'b0, scnt_reg} + 17'd1) >= sps_eff;
        last_bit    = (CMP_W'(idx_reg) + CMP_W'(1)) >= nbits;
        fe          = last_sample && last_bit;
        done        = fe && (rep_reg <= 8'd1);

        if (tx_reg) begin
            result.dac_sample  = bit_val ? sine_val : DAC_MID;
            result.active      = 1'b1;
            result.current_bit = bit_val;
            result.frame_end   = fe;
            result.all_done    = done;
        end else begin
            result.dac_sample  = DAC_MID;
            result.active      = 1'b0;
            result.current_bit = 1'b0;
            result.frame_end   = 1'b0;
            result.all_done    = 1'b0;
        end
    end

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        scnt_next  = scnt_reg;
        phase_next = phase_reg;
        rep_next   = rep_reg;
        tx_next    = tx_reg;
        wr_en      = 1'b0;
        if (item_go && (item.func == FUNC_LOAD) && !tx_reg) begin
            if (count_reg < CNT_W'(MSG_BYTES)) begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            if (item.end_of_message) begin
                tx_next    = 1'b1;
                idx_next   = '0;
                scnt_next  = '0;
                phase_next = '0;
                rep_next   = (cfg.repeat_count == '0) ? 8'd1 : cfg.repeat_count;
            end
        end else if (item_go && (item.func == FUNC_TICK) && tx_reg) begin
            if (last_sample) begin
                scnt_next  = '0;
                phase_next = '0;
                if (last_bit) begin
                    idx_next = '0;
                    if (done) begin
                        tx_next    = 1'b0;
                        count_next = '0;
                        rep_next   = '0;
                    end else begin
                        rep_next = rep_reg - 8'd1;
                    end
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end else begin
                scnt_next  = scnt_reg + 16'd1;
                phase_next = PHASE_BITS'(SUM_W'(phase_reg) + SUM_W'(cfg.phase_step));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
            scnt_reg  <= '0;
            phase_reg <= '0;
            rep_reg   <= '0;
            tx_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            scnt_reg  <= scnt_next;
            phase_reg <= phase_next;
            rep_reg   <= rep_next;
            tx_reg    <= tx_next;
        end
    end

endmodule
